/* sv/dlpg_pkg.sv */
package dlpg_pkg;

  // coordinate and counter widths
  localparam int COORD_BITS = 8;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int LEFT_BITS  = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [LEFT_BITS-1:0]  left_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [1:0]            step_t;
  typedef logic                  cmd_t;

  // step direction codes
  localparam step_t STEP_NONE  = 2'd0;
  localparam step_t STEP_PLUS  = 2'd1;
  localparam step_t STEP_MINUS = 2'd3;

  // command codes
  localparam cmd_t CMD_START = 1'b0;
  localparam cmd_t CMD_NEXT  = 1'b1;

  // one input item
  typedef struct packed {
    cmd_t   cmd;
    coord_t x_from;
    coord_t y_from;
    coord_t x_to;
    coord_t y_to;
    color_t pixel_color;
  } item_t;

  // one emitted pixel
  typedef struct packed {
    coord_t px;
    coord_t py;
    color_t out_color;
    logic   last;
  } pixel_t;

  // line parameters derived from the endpoints
  typedef struct packed {
    coord_t abs_dx;
    coord_t abs_dy;
    step_t  step_x;
    step_t  step_y;
    coord_t major_len;
    left_t  pixels_left;
  } setup_t;

  // core status seen by the top level
  typedef struct packed {
    logic   busy;
    left_t  pixels_left;
    coord_t major_len;
    err_t   err_x;
    err_t   err_y;
  } status_t;

endpackage

/* sv/dlpg_setup.sv */
module dlpg_setup (
  input  dlpg_pkg::coord_t x_from,
  input  dlpg_pkg::coord_t y_from,
  input  dlpg_pkg::coord_t x_to,
  input  dlpg_pkg::coord_t y_to,
  output dlpg_pkg::setup_t setup
);

  dlpg_pkg::coord_t dx;
  dlpg_pkg::coord_t dy;
  dlpg_pkg::step_t  sx;
  dlpg_pkg::step_t  sy;
  dlpg_pkg::coord_t major;

  // x delta and direction
  always_comb begin
    if (x_to > x_from) begin
      dx = x_to - x_from;
      sx = dlpg_pkg::STEP_PLUS;
    end else if (x_to == x_from) begin
      dx = '0;
      sx = dlpg_pkg::STEP_NONE;
    end else begin
      dx = x_from - x_to;
      sx = dlpg_pkg::STEP_MINUS;
    end
  end

  // y delta and direction
  always_comb begin
    if (y_to > y_from) begin
      dy = y_to - y_from;
      sy = dlpg_pkg::STEP_PLUS;
    end else if (y_to == y_from) begin
      dy = '0;
      sy = dlpg_pkg::STEP_NONE;
    end else begin
      dy = y_from - y_to;
      sy = dlpg_pkg::STEP_MINUS;
    end
  end

  assign major = (dx > dy) ? dx : dy;

  // pixel count is major length plus two, start pixel repeats
  assign setup.abs_dx      = dx;
  assign setup.abs_dy      = dy;
  assign setup.step_x      = sx;
  assign setup.step_y      = sy;
  assign setup.major_len   = major;
  assign setup.pixels_left = {1'b0, major} + dlpg_pkg::left_t'(2);

endmodule

/* sv/dlpg_core.sv */
module dlpg_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  dlpg_pkg::item_t   item,
  output logic              emit,
  output dlpg_pkg::pixel_t  pixel,
  output dlpg_pkg::status_t status
);

  logic             busy;
  dlpg_pkg::coord_t cur_x;
  dlpg_pkg::coord_t cur_y;
  dlpg_pkg::coord_t abs_dx;
  dlpg_pkg::coord_t abs_dy;
  dlpg_pkg::step_t  step_x;
  dlpg_pkg::step_t  step_y;
  dlpg_pkg::coord_t major_len;
  dlpg_pkg::err_t   err_x;
  dlpg_pkg::err_t   err_y;
  dlpg_pkg::left_t  pixels_left;
  dlpg_pkg::color_t line_color;

  dlpg_pkg::setup_t setup;
  logic             start;
  dlpg_pkg::left_t  left_dec;
  dlpg_pkg::err_t   sum_x;
  dlpg_pkg::err_t   sum_y;
  dlpg_pkg::err_t   major_ext;
  dlpg_pkg::err_t   err_x_next;
  dlpg_pkg::err_t   err_y_next;
  dlpg_pkg::coord_t cur_x_next;
  dlpg_pkg::coord_t cur_y_next;

  dlpg_setup u_setup (
    .x_from (item.x_from),
    .y_from (item.y_from),
    .x_to   (item.x_to),
    .y_to   (item.y_to),
    .setup  (setup)
  );

  function automatic dlpg_pkg::coord_t move(dlpg_pkg::coord_t pos, dlpg_pkg::step_t dir);
    dlpg_pkg::coord_t res;
    case (dir)
      dlpg_pkg::STEP_PLUS:  res = pos + dlpg_pkg::coord_t'(1);
      dlpg_pkg::STEP_MINUS: res = pos - dlpg_pkg::coord_t'(1);
      default:              res = pos;
    endcase
    return res;
  endfunction

  assign start    = advance && (item.cmd == dlpg_pkg::CMD_START);
  assign emit     = advance && (item.cmd == dlpg_pkg::CMD_NEXT) && busy;
  assign left_dec = pixels_left - dlpg_pkg::left_t'(1);

  // error accumulation, step when error passes the major length
  assign major_ext = dlpg_pkg::err_t'(major_len);
  assign sum_x     = err_x + dlpg_pkg::err_t'(abs_dx);
  assign sum_y     = err_y + dlpg_pkg::err_t'(abs_dy);

  always_comb begin
    err_x_next = sum_x;
    cur_x_next = cur_x;
    if (sum_x > major_ext) begin
      err_x_next = sum_x - major_ext;
      cur_x_next = move(cur_x, step_x);
    end
    err_y_next = sum_y;
    cur_y_next = cur_y;
    if (sum_y > major_ext) begin
      err_y_next = sum_y - major_ext;
      cur_y_next = move(cur_y, step_y);
    end
  end

  // pixel for the current request
  assign pixel.px        = cur_x;
  assign pixel.py        = cur_y;
  assign pixel.out_color = line_color;
  assign pixel.last      = (left_dec == '0);

  assign status.busy        = busy;
  assign status.pixels_left = pixels_left;
  assign status.major_len   = major_len;
  assign status.err_x       = err_x;
  assign status.err_y       = err_y;

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      step_x      <= dlpg_pkg::STEP_NONE;
      step_y      <= dlpg_pkg::STEP_NONE;
      major_len   <= '0;
      err_x       <= '0;
      err_y       <= '0;
      pixels_left <= '0;
      line_color  <= '0;
    end else if (start) begin
      busy        <= 1'b1;
      cur_x       <= item.x_from;
      cur_y       <= item.y_from;
      abs_dx      <= setup.abs_dx;
      abs_dy      <= setup.abs_dy;
      step_x      <= setup.step_x;
      step_y      <= setup.step_y;
      major_len   <= setup.major_len;
      err_x       <= '0;
      err_y       <= '0;
      pixels_left <= setup.pixels_left;
      line_color  <= item.pixel_color;
    end else if (emit) begin
      busy        <= (left_dec != '0);
      pixels_left <= left_dec;
      err_x       <= err_x_next;
      err_y       <= err_y_next;
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
    end
  end

endmodule

/* sv/dda_line_point_generator.sv */
// Line point generator. A start transfer (tuser = 0) loads both endpoints and the
// color and returns nothing; each next transfer (tuser = 1) returns one pixel until
// max(|dx|,|dy|) + 2 pixels have gone out, the start pixel coming twice and the
// final pixel marked by tlast. A next transfer with no line running returns nothing,
// and a start transfer drops any line in progress. The block takes one transfer
// every cycle while the output is not held; a pixel goes from the input register
// through the line state into the output register, while the error add and compare
// for each axis update the line state in that same cycle.
// The output register holds a waiting pixel; input stalls once the input register
// also holds an item.
module dda_line_point_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // x_from, y_from, x_to, y_to, pixel_color
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // px, py, out_color
  output logic        m_axis_tlast   // last
);

  logic              in_valid;
  dlpg_pkg::item_t   in_item;
  logic              advance;
  logic              emit;
  dlpg_pkg::pixel_t  pixel;
  dlpg_pkg::status_t status;
  logic              out_valid;
  dlpg_pkg::pixel_t  out_pixel;
  logic              out_free;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.cmd         <= dlpg_pkg::cmd_t'(s_axis_tuser);
      in_item.x_from      <= dlpg_pkg::coord_t'(s_axis_tdata[7:0]);
      in_item.y_from      <= dlpg_pkg::coord_t'(s_axis_tdata[15:8]);
      in_item.x_to        <= dlpg_pkg::coord_t'(s_axis_tdata[23:16]);
      in_item.y_to        <= dlpg_pkg::coord_t'(s_axis_tdata[31:24]);
      in_item.pixel_color <= s_axis_tdata[47:32];
    end
  end

  dlpg_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .emit    (emit),
    .pixel   (pixel),
    .status  (status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_pixel <= pixel;
    end
  end

  assign m_axis_tvalid        = out_valid;
  assign m_axis_tdata[7:0]    = 8'(out_pixel.px);
  assign m_axis_tdata[15:8]   = 8'(out_pixel.py);
  assign m_axis_tdata[31:16]  = out_pixel.out_color;
  assign m_axis_tlast         = out_pixel.last;

  // a line is running exactly while pixels remain
  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    status.busy == (status.pixels_left != '0))
    else $error("busy flag and pixel count disagree");

  // error terms never exceed the major length
  a_err_bound: assert property (@(posedge clk) disable iff (rst)
    (dlpg_pkg::err_t'(status.major_len) >= status.err_x) &&
    (dlpg_pkg::err_t'(status.major_len) >= status.err_y))
    else $error("error term above major length");

  // emitting the final pixel ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && pixel.last) |=> !status.busy)
    else $error("line still running after final pixel");

  // a pixel is only produced from a running line
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    emit |-> (status.busy && advance))
    else $error("pixel produced while idle");

endmodule

/* tb/sv/testbench.sv */
module testbench;
  import dlpg_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int TARGET_ITEMS = 1150;

  typedef enum {ROW_PREDICT, ROW_SILENT, ROW_GIVEN} row_kind_e;

  typedef struct {
    item_t     it;
    row_kind_e kind;
    pixel_t    given;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // x_from, y_from, x_to, y_to, pixel_color
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // px, py, out_color
  logic        m_axis_tlast;   // last

  dda_line_point_generator u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // line walker state, mirrors the block
  logic   line_busy;
  coord_t walk_x, walk_y, delta_x, delta_y, major_len;
  step_t  dir_x, dir_y;
  err_t   acc_x, acc_y;
  left_t  pixels_left;
  color_t line_color;

  pixel_t pixels_due[$];
  row_t   script[$];
  int     errors;
  int     meaningful;
  int     hold_reqs;
  int     holds_done;
  int     rx_cycles;
  int     quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void axis_setup(input coord_t from_c, input coord_t to_c,
                                     output coord_t delta, output step_t dir);
    if (to_c > from_c) begin
      delta = to_c - from_c;
      dir = STEP_PLUS;
    end else if (to_c == from_c) begin
      delta = '0;
      dir = STEP_NONE;
    end else begin
      delta = from_c - to_c;
      dir = STEP_MINUS;
    end
  endfunction

  function automatic coord_t stepped(input coord_t pos, input step_t dir);
    if (dir == STEP_PLUS) return pos + coord_t'(1);
    if (dir == STEP_MINUS) return pos - coord_t'(1);
    return pos;
  endfunction

  // advance the walker by one accepted transfer
  task automatic walk_line(input item_t it, output bit emits, output pixel_t pix);
    emits = 1'b0;
    pix = '0;
    if (it.cmd == CMD_START) begin
      axis_setup(it.x_from, it.x_to, delta_x, dir_x);
      axis_setup(it.y_from, it.y_to, delta_y, dir_y);
      major_len = (delta_x > delta_y) ? delta_x : delta_y;
      walk_x = it.x_from;
      walk_y = it.y_from;
      acc_x = '0;
      acc_y = '0;
      pixels_left = left_t'(major_len) + left_t'(2);
      line_color = it.pixel_color;
      line_busy = 1'b1;
    end else if (line_busy) begin
      emits = 1'b1;
      pixels_left = pixels_left - left_t'(1);
      pix.px = walk_x;
      pix.py = walk_y;
      pix.out_color = line_color;
      pix.last = (pixels_left == '0);
      if (pixels_left == '0) line_busy = 1'b0;
      acc_x = acc_x + err_t'(delta_x);
      acc_y = acc_y + err_t'(delta_y);
      if (acc_x > err_t'(major_len)) begin
        acc_x = acc_x - err_t'(major_len);
        walk_x = stepped(walk_x, dir_x);
      end
      if (acc_y > err_t'(major_len)) begin
        acc_y = acc_y - err_t'(major_len);
        walk_y = stepped(walk_y, dir_y);
      end
    end
  endtask

  function automatic item_t start_of(input coord_t x0, input coord_t y0, input coord_t x1,
                                     input coord_t y1, input color_t col);
    item_t it;
    it.cmd = CMD_START;
    it.x_from = x0;
    it.y_from = y0;
    it.x_to = x1;
    it.y_to = y1;
    it.pixel_color = col;
    return it;
  endfunction

  function automatic item_t random_next();
    item_t it;
    it.cmd = CMD_NEXT;
    it.x_from = coord_t'($urandom);
    it.y_from = coord_t'($urandom);
    it.x_to = coord_t'($urandom);
    it.y_to = coord_t'($urandom);
    it.pixel_color = color_t'($urandom);
    return it;
  endfunction

  function automatic coord_t near_coord(input coord_t base, input int reach);
    int v;
    v = int'(base) + int'($urandom_range(2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return coord_t'(v);
  endfunction

  task automatic add_row(input item_t it, input row_kind_e kind, input pixel_t given);
    row_t r;
    r.it = it;
    r.kind = kind;
    r.given = given;
    script.push_back(r);
  endtask

  // offer one transfer, wait for the handshake, then record what it should produce
  task automatic send_item(input item_t it, input row_kind_e kind, input pixel_t given);
    bit     emits;
    pixel_t pix;
    bit     calm;
    calm = (meaningful >= 250) && (meaningful < 450);
    if (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.pixel_color, it.y_to, it.x_to, it.y_from, it.x_from};
    s_axis_tuser <= it.cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    walk_line(it, emits, pix);
    if (it.cmd == CMD_START || emits) meaningful++;
    case (kind)
      ROW_SILENT: ;
      ROW_GIVEN: pixels_due.push_back(given);
      default: if (emits) pixels_due.push_back(pix);
    endcase
  endtask

  // directed rows: reset state, extremes, zero length, restart while busy
  task automatic build_script();
    item_t nx;
    nx = '0;
    nx.cmd = CMD_NEXT;
    add_row(nx, ROW_SILENT, '0);
    add_row(start_of(8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF), ROW_SILENT, '0);
    add_row(nx, ROW_GIVEN, '{8'd0, 8'd0, 16'hFFFF, 1'b0});
    add_row(nx, ROW_GIVEN, '{8'd0, 8'd0, 16'hFFFF, 1'b1});
    add_row(nx, ROW_SILENT, '0);
    add_row(start_of(8'd255, 8'd255, 8'd0, 8'd0, 16'h0000), ROW_SILENT, '0);
    add_row(nx, ROW_GIVEN, '{8'd255, 8'd255, 16'h0000, 1'b0});
    add_row(nx, ROW_GIVEN, '{8'd255, 8'd255, 16'h0000, 1'b0});
    add_row(nx, ROW_PREDICT, '0);
    add_row(nx, ROW_PREDICT, '0);
    add_row(start_of(8'd0, 8'd255, 8'd255, 8'd0, 16'hA5A5), ROW_SILENT, '0);
    add_row(nx, ROW_GIVEN, '{8'd0, 8'd255, 16'hA5A5, 1'b0});
    add_row(nx, ROW_PREDICT, '0);
    add_row(start_of(8'd10, 8'd20, 8'd200, 8'd30, 16'h5A5A), ROW_SILENT, '0);
    repeat (3) add_row(nx, ROW_PREDICT, '0);
    add_row(start_of(8'd128, 8'd0, 8'd128, 8'd255, 16'h1234), ROW_SILENT, '0);
    repeat (2) add_row(nx, ROW_PREDICT, '0);
    add_row(start_of(8'd3, 8'd7, 8'd5, 8'd4, 16'h0F0F), ROW_SILENT, '0);
    repeat (6) add_row(nx, ROW_PREDICT, '0);
  endtask

  // stimulus
  initial begin
    coord_t x0, y0, x1, y1;
    int     len, n_next;
    bit     long_done, pause_done;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= CMD_NEXT;
    line_busy = 1'b0;
    walk_x = '0;
    walk_y = '0;
    delta_x = '0;
    delta_y = '0;
    major_len = '0;
    dir_x = STEP_NONE;
    dir_y = STEP_NONE;
    acc_x = '0;
    acc_y = '0;
    pixels_left = '0;
    line_color = '0;
    errors = 0;
    meaningful = 0;
    hold_reqs = 0;
    long_done = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_script();
    foreach (script[i]) send_item(script[i].it, script[i].kind, script[i].given);

    while (meaningful < TARGET_ITEMS) begin
      // sender pause until the block has drained
      if (!pause_done && meaningful >= 850) begin
        pause_done = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0) @(posedge clk);
      end
      // noise: stray next transfers
      if ($urandom_range(99) < 5) begin
        send_item(random_next(), ROW_PREDICT, '0);
        continue;
      end
      x0 = coord_t'($urandom);
      y0 = coord_t'($urandom);
      if (!long_done && meaningful >= 500) begin
        // long line while the receiver holds off
        long_done = 1'b1;
        x0 = 8'd0;
        x1 = 8'd255;
        y1 = coord_t'($urandom);
        hold_reqs++;
      end else if ($urandom_range(99) < 75) begin
        x1 = near_coord(x0, 8);
        y1 = near_coord(y0, 8);
      end else begin
        x1 = coord_t'($urandom);
        y1 = coord_t'($urandom);
      end
      send_item(start_of(x0, y0, x1, y1, color_t'($urandom)), ROW_PREDICT, '0);
      len = int'(major_len) + 2;
      if ($urandom_range(99) < 15) n_next = $urandom_range(0, len - 1);  // cut short by a restart
      else n_next = len + $urandom_range(0, 2);
      repeat (n_next) send_item(random_next(), ROW_PREDICT, '0);
    end
    s_axis_tvalid <= 1'b0;

    // drain and let any pipeline work settle
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: random backpressure, an always-ready window, one long hold-off on request
  initial begin
    holds_done = 0;
    rx_cycles = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (hold_reqs != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (rx_cycles >= 700 && rx_cycles < 1100) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 13);
      end
    end
  end

  // pixel checker
  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.px = m_axis_tdata[7:0];
      got.py = m_axis_tdata[15:8];
      got.out_color = m_axis_tdata[31:16];
      got.last = m_axis_tlast;
      if (pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel px=%0d py=%0d color=%h last=%b",
                 $time, got.px, got.py, got.out_color, got.last);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        if (got !== want) begin
          $display("%0t: pixel mismatch expected px=%0d py=%0d color=%h last=%b",
                   $time, want.px, want.py, want.out_color, want.last);
          $display("%0t:                actual   px=%0d py=%0d color=%h last=%b",
                   $time, got.px, got.py, got.out_color, got.last);
          errors++;
        end
      end
    end
  end

  // watchdog on transfers in either direction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
